### design/rpkbc_pkg.sv
// ----------------------------------------------------------------------------
// rpkbc_pkg
// Shared types and constants for the position-keyed RSA byte cipher.
// ----------------------------------------------------------------------------
package rpkbc_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned MAX_LEN_DEF   = 4096;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned CFG_BITS   = 2;

  typedef logic [CFG_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MODE     = 2'd0;
  localparam cfg_idx_t CFG_EXPONENT = 2'd1;
  localparam cfg_idx_t CFG_MODULUS  = 2'd2;

  localparam logic [FIELD_BITS-1:0] EXPONENT_RESET = 32'd3;
  localparam logic [FIELD_BITS-1:0] MODULUS_RESET  = 32'd187;

  localparam logic MODE_ENCRYPT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RED,
    ST_TEST,
    ST_ACC,
    ST_SQ,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    MUL_REDUCE,
    MUL_ACC,
    MUL_SQUARE
  } mul_sel_e;

  typedef struct packed {
    logic     accept;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     base_wr;
    logic     acc_wr;
    logic     exp_shift;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic mod_zero;
    logic exp_zero;
    logic exp_bit;
    logic out_free;
  } sts_t;

endpackage

### design/rpkbc_modmul.sv
// ----------------------------------------------------------------------------
// rpkbc_modmul
// Interleaved shift-add modular multiplier, one bit of the first operand
// per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module rpkbc_modmul import rpkbc_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned OPND_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [OPND_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0] m_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] p_o
);

  localparam int unsigned CNT_BITS = $clog2(OPND_BITS + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic [OPND_BITS-1:0] a_q;
  logic [WORD_BITS-1:0] b_q;
  logic [WORD_BITS-1:0] m_q;
  logic [WORD_BITS-1:0] r_q;
  logic [WORD_BITS-1:0] r_d;
  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   dbl_red;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   m_ext;

  always_comb begin
    m_ext   = {1'b0, m_q};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = dbl_red + (a_q[OPND_BITS-1] ? {1'b0, b_q} : '0);
    r_d     = (sum >= m_ext) ? WORD_BITS'(sum - m_ext) : WORD_BITS'(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(OPND_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      m_q <= m_i;
      r_q <= '0;
    end else if (busy_q) begin
      a_q <= {a_q[OPND_BITS-2:0], 1'b0};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = r_q;

`ifndef ASSERT_OFF
  a_done_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && m_q != '0) |-> (r_q < m_q))
    else $error("modmul result not below modulus");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("modmul started while busy");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == CNT_BITS'(1)) |=> (done_q && !busy_q))
    else $error("modmul did not finish after last bit");
`endif

endmodule

### design/rpkbc_datapath.sv
// ----------------------------------------------------------------------------
// rpkbc_datapath
// Configuration registers, position counter, exponentiation registers and
// the output register around a shared modular multiplier.
// ----------------------------------------------------------------------------
module rpkbc_datapath import rpkbc_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned MAX_LEN   = MAX_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  cfg_valid_i,
  input  cfg_idx_t              cfg_index_i,
  input  logic [FIELD_BITS-1:0] cfg_data_i,
  input  logic [FIELD_BITS-1:0] in_value_i,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [FIELD_BITS-1:0] out_value_o,
  output logic                  out_last_o
);

  localparam int unsigned POS_BITS  = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned BASE_BITS = ((POS_BITS > 8) ? POS_BITS : 8) + 1;
  localparam int unsigned OPND_BITS = (WORD_BITS > BASE_BITS) ? WORD_BITS : BASE_BITS;

  logic                  mode_q;
  logic [WORD_BITS-1:0]  exponent_q;
  logic [WORD_BITS-1:0]  modulus_q;
  logic [POS_BITS-1:0]   pos_q;
  logic [7:0]            pos_item_q;
  logic                  last_q;
  logic [OPND_BITS-1:0]  base_q;
  logic [WORD_BITS-1:0]  acc_q;
  logic [WORD_BITS-1:0]  exp_q;
  logic                  out_valid_q;
  logic [FIELD_BITS-1:0] out_value_q;
  logic                  out_last_q;

  logic [OPND_BITS-1:0]  base_in;
  logic [WORD_BITS-1:0]  one_mod_m;
  logic [OPND_BITS-1:0]  mul_a;
  logic [WORD_BITS-1:0]  mul_b;
  logic                  mul_done;
  logic [WORD_BITS-1:0]  mul_p;
  logic [7:0]            dec_byte;

  assign one_mod_m = (modulus_q > WORD_BITS'(1)) ? WORD_BITS'(1) : '0;
  assign dec_byte  = acc_q[7:0] - pos_item_q;

  always_comb begin
    if (mode_q == MODE_ENCRYPT) begin
      base_in = OPND_BITS'(in_value_i[7:0]) + OPND_BITS'(pos_q);
    end else begin
      base_in = OPND_BITS'(in_value_i[WORD_BITS-1:0]);
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_REDUCE: begin
        mul_a = base_q;
        mul_b = one_mod_m;
      end
      MUL_ACC: begin
        mul_a = OPND_BITS'(acc_q);
        mul_b = base_q[WORD_BITS-1:0];
      end
      MUL_SQUARE: begin
        mul_a = OPND_BITS'(base_q[WORD_BITS-1:0]);
        mul_b = base_q[WORD_BITS-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rpkbc_modmul #(
    .WORD_BITS (WORD_BITS),
    .OPND_BITS (OPND_BITS)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (modulus_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ENCRYPT;
      exponent_q  <= WORD_BITS'(EXPONENT_RESET);
      modulus_q   <= WORD_BITS'(MODULUS_RESET);
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MODE:     mode_q     <= cfg_data_i[0];
          CFG_EXPONENT: exponent_q <= cfg_data_i[WORD_BITS-1:0];
          CFG_MODULUS:  modulus_q  <= cfg_data_i[WORD_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.accept) begin
        if (in_last_i || pos_q == POS_BITS'(MAX_LEN - 1)) begin
          pos_q <= '0;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      base_q     <= base_in;
      acc_q      <= one_mod_m;
      exp_q      <= exponent_q;
      pos_item_q <= 8'(pos_q);
      last_q     <= in_last_i;
    end else begin
      if (cmd_i.base_wr) begin
        base_q <= OPND_BITS'(mul_p);
      end
      if (cmd_i.acc_wr) begin
        acc_q <= mul_p;
      end
      if (cmd_i.exp_shift) begin
        exp_q <= exp_q >> 1;
      end
    end
    if (cmd_i.out_load) begin
      out_last_q <= last_q;
      if (mode_q == MODE_ENCRYPT) begin
        out_value_q <= FIELD_BITS'(acc_q);
      end else begin
        out_value_q <= FIELD_BITS'(dec_byte);
      end
    end
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.mod_zero = (modulus_q == '0);
  assign sts_o.exp_zero = (exp_q == '0);
  assign sts_o.exp_bit  = exp_q[0];
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

### design/rpkbc_ctrl.sv
// ----------------------------------------------------------------------------
// rpkbc_ctrl
// Sequencer for right-to-left square-and-multiply exponentiation.
// ----------------------------------------------------------------------------
module rpkbc_ctrl import rpkbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = sts_i.mod_zero ? ST_FINISH : ST_RED;
      end
      ST_RED: begin
        if (sts_i.mul_done) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts_i.exp_zero) begin
          state_d = ST_FINISH;
        end else if (sts_i.exp_bit) begin
          state_d = ST_ACC;
        end else begin
          state_d = ST_SQ;
        end
      end
      ST_ACC: begin
        if (sts_i.mul_done) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sts_i.mul_done) begin
          state_d = ST_TEST;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_LOAD: begin
        cmd_o.mul_start = !sts_i.mod_zero;
        cmd_o.mul_sel   = MUL_REDUCE;
      end
      ST_RED: begin
        cmd_o.mul_sel = MUL_REDUCE;
        cmd_o.base_wr = sts_i.mul_done;
      end
      ST_TEST: begin
        cmd_o.mul_start = !sts_i.exp_zero;
        cmd_o.mul_sel   = sts_i.exp_bit ? MUL_ACC : MUL_SQUARE;
      end
      ST_ACC: begin
        cmd_o.acc_wr    = sts_i.mul_done;
        cmd_o.mul_start = sts_i.mul_done;
        cmd_o.mul_sel   = sts_i.mul_done ? MUL_SQUARE : MUL_ACC;
      end
      ST_SQ: begin
        cmd_o.mul_sel   = MUL_SQUARE;
        cmd_o.base_wr   = sts_i.mul_done;
        cmd_o.exp_shift = sts_i.mul_done;
      end
      ST_FINISH: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_LOAD))
    else $error("accepted word did not enter load");
  a_start_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |=> (state_q == ST_RED || state_q == ST_ACC || state_q == ST_SQ))
    else $error("multiplier started outside a wait state");
  a_finish_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == ST_IDLE && !cmd_o.out_load))
    else $error("result loaded without returning to idle");
`endif

endmodule

### design/rsa_position_keyed_byte_cipher.sv
// ----------------------------------------------------------------------------
// rsa_position_keyed_byte_cipher
// Textbook RSA over a buffer, one word at a time, keyed by buffer position.
//
//   channel  direction  handshake                    payload
//   cfg      in         cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o      in_value_i, in_last_i
//   out      out        out_valid_o / out_stall_i    out_value_o, out_last_o
//
// Each word is worked by the bit-serial modular multiplier, whose operand width
// is 32 by default; the work ends after the highest set exponent bit.
// Reset clears the controller and the position and returns the configuration
// registers to their reset values.
// A stalled result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module rsa_position_keyed_byte_cipher import rpkbc_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned MAX_LEN   = MAX_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  cfg_idx_t              cfg_index_i,
  input  logic [FIELD_BITS-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FIELD_BITS-1:0] in_value_i,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [FIELD_BITS-1:0] out_value_o,
  output logic                  out_last_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  rpkbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpkbc_datapath #(
    .WORD_BITS (WORD_BITS),
    .MAX_LEN   (MAX_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_value_i  (in_value_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (out_value_o),
    .out_last_o  (out_last_o)
  );

endmodule

### tb/rsa_position_keyed_byte_cipher_tb.sv
// ----------------------------------------------------------------------------
// rsa_position_keyed_byte_cipher_tb
// Self-checking bench for the position-keyed RSA byte cipher. A driver feeds
// words from a queue and predicts each result at acceptance by modular
// exponentiation with the current key, mode and buffer position. A monitor
// compares every result word with the oldest prediction. The run covers the
// reset key, the edge cases of the key, and random buffers under several
// idle patterns, with a long receiver hold-off and a full drain between key
// changes.
// ----------------------------------------------------------------------------
module rsa_position_keyed_byte_cipher_tb;
  import rpkbc_pkg::*;

  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 2400;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned POS_BITS     = $clog2(MAX_LEN_DEF);
  localparam cfg_idx_t    CFG_UNMAPPED = 2'd3;
  localparam logic        MODE_DECRYPT = ~MODE_ENCRYPT;

  typedef struct {
    logic [FIELD_BITS-1:0] value;
    logic                  last;
  } cipher_word_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_t              cfg_index_i = CFG_MODE;
  logic [FIELD_BITS-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [FIELD_BITS-1:0] in_value_i  = '0;
  logic                  in_last_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [FIELD_BITS-1:0] out_value_o;
  logic                  out_last_o;

  cipher_word_t word_feed_q[$];
  cipher_word_t modexp_results_q[$];
  cipher_word_t taken_word, next_word, want_word;

  logic                  key_mode     = MODE_ENCRYPT;
  logic [FIELD_BITS-1:0] key_exponent = EXPONENT_RESET;
  logic [FIELD_BITS-1:0] key_modulus  = MODULUS_RESET;
  logic [POS_BITS-1:0]   buf_position = '0;

  int unsigned words_in_flight = 0;
  int unsigned mismatches      = 0;
  int unsigned send_idle_pct   = 33;
  int unsigned recv_idle_pct   = 75;
  int unsigned hold_reqs       = 0;
  int unsigned hold_seen       = 0;
  int unsigned hold_left       = 0;
  int unsigned quiet_cycles    = 0;

  rsa_position_keyed_byte_cipher u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_value_i  (in_value_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (out_value_o),
    .out_last_o  (out_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [FIELD_BITS-1:0] mod_exp(logic [FIELD_BITS-1:0] base,
                                                    logic [FIELD_BITS-1:0] expo,
                                                    logic [FIELD_BITS-1:0] modu);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] m64;
    if (modu == '0) begin
      return '0;
    end
    m64 = 64'(modu);
    acc = 64'd1 % m64;
    sq  = 64'(base) % m64;
    for (int i = 0; i < FIELD_BITS; i++) begin
      if (expo[i]) begin
        acc = (acc * sq) % m64;
      end
      sq = (sq * sq) % m64;
    end
    return acc[FIELD_BITS-1:0];
  endfunction

  function automatic void cipher_step(cipher_word_t w);
    cipher_word_t          r;
    logic [FIELD_BITS-1:0] power;
    logic [7:0]            plain;
    if (key_mode == MODE_ENCRYPT) begin
      r.value = mod_exp(32'(w.value[7:0]) + 32'(buf_position), key_exponent, key_modulus);
    end else begin
      power   = mod_exp(w.value, key_exponent, key_modulus);
      plain   = power[7:0] - buf_position[7:0];
      r.value = 32'(plain);
    end
    r.last = w.last;
    modexp_results_q.push_back(r);
    if (w.last || buf_position == POS_BITS'(MAX_LEN_DEF - 1)) begin
      buf_position = '0;
    end else begin
      buf_position = buf_position + 1'b1;
    end
  endfunction

  function automatic void push_word(logic [FIELD_BITS-1:0] value, logic last);
    cipher_word_t w;
    w.value = value;
    w.last  = last;
    word_feed_q.push_back(w);
  endfunction

  function automatic logic [FIELD_BITS-1:0] random_word();
    if (key_mode == MODE_DECRYPT && key_modulus != '0 && $urandom_range(3) != 0) begin
      return $urandom % key_modulus;
    end
    return $urandom;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [FIELD_BITS-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MODE:     key_mode     = data[0];
      CFG_EXPONENT: key_exponent = data;
      CFG_MODULUS:  key_modulus  = data;
      default:      ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (word_feed_q.size() != 0 || words_in_flight != 0 || modexp_results_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_buffers(int unsigned count);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 10);
      if (len > count - sent) begin
        len = count - sent;
      end
      for (int unsigned i = 0; i < len; i++) begin
        push_word(random_word(), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic random_phase(int unsigned count, bit long_exp, bit hold, bit pause);
    wait_drained();
    write_reg(CFG_MODE, 32'($urandom_range(1)));
    if (long_exp) begin
      write_reg(CFG_EXPONENT, $urandom | 32'h8000_0000);
    end else if ($urandom_range(3) == 0) begin
      write_reg(CFG_EXPONENT, $urandom_range(15));
    end else begin
      write_reg(CFG_EXPONENT, $urandom_range(255));
    end
    case ($urandom_range(2))
      0:       write_reg(CFG_MODULUS, $urandom_range(32'hFFFF_FFFF, 2));
      1:       write_reg(CFG_MODULUS, $urandom_range(1000, 2));
      default: write_reg(CFG_MODULUS, MODULUS_RESET);
    endcase
    if ($urandom_range(2) == 0) begin
      write_reg(CFG_UNMAPPED, $urandom);
    end
    if (pause) begin
      push_buffers(count / 2);
      wait_drained();
      push_buffers(count - count / 2);
    end else begin
      push_buffers(count);
    end
    if (hold) begin
      hold_reqs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        taken_word.value = in_value_i;
        taken_word.last  = in_last_i;
        cipher_step(taken_word);
        words_in_flight--;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (word_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = word_feed_q.pop_front();
          words_in_flight++;
          in_valid_i <= 1'b1;
          in_value_i <= next_word.value;
          in_last_i  <= next_word.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (modexp_results_q.size() == 0) begin
          $error("out_value: expected no word, actual %h", out_value_o);
          mismatches++;
        end else begin
          want_word = modexp_results_q.pop_front();
          if (out_value_o !== want_word.value) begin
            $error("out_value: expected %h, actual %h", want_word.value, out_value_o);
            mismatches++;
          end
          if (out_last_o !== want_word.last) begin
            $error("out_last: expected %b, actual %b", want_word.last, out_last_o);
            mismatches++;
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL rsa_position_keyed_byte_cipher");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_word(32'h0000_0000, 1'b0);
    push_word(32'h0000_00FF, 1'b0);
    push_word(32'hFFFF_FF00, 1'b0);
    push_word(32'hA5A5_A5B4, 1'b1);
    wait_drained();

    write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    write_reg(CFG_MODE, 32'(MODE_DECRYPT));
    write_reg(CFG_EXPONENT, 32'd107);
    push_word(32'd0, 1'b0);
    push_word(32'd186, 1'b0);
    push_word(32'd187, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    wait_drained();

    write_reg(CFG_MODE, 32'(MODE_ENCRYPT));
    write_reg(CFG_EXPONENT, 32'd0);
    push_word(32'h0000_0012, 1'b0);
    push_word(32'h0000_00FF, 1'b1);
    wait_drained();

    write_reg(CFG_MODULUS, 32'd1);
    push_word(32'h0000_0034, 1'b1);
    wait_drained();

    write_reg(CFG_EXPONENT, 32'd5);
    write_reg(CFG_MODULUS, 32'd0);
    push_word(32'h0000_0056, 1'b0);
    wait_drained();
    write_reg(CFG_MODE, 32'(MODE_DECRYPT));
    push_word(32'h0000_0078, 1'b0);
    push_word(32'h0000_009A, 1'b1);
    wait_drained();

    write_reg(CFG_MODE, 32'(MODE_ENCRYPT));
    write_reg(CFG_EXPONENT, 32'hFFFF_FFFF);
    write_reg(CFG_MODULUS, 32'hFFFF_FFFF);
    push_word(32'h0000_00FE, 1'b0);
    push_word(32'h0000_0001, 1'b1);
    wait_drained();
    write_reg(CFG_MODE, 32'(MODE_DECRYPT));
    push_word(32'hFFFF_FFFE, 1'b1);

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 33;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 2 || ph == 5) begin
        random_phase(4, 1'b1, 1'b0, 1'b0);
      end else begin
        random_phase(36, 1'b0, ph == 4, ph == 1);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && modexp_results_q.size() == 0) begin
      $display("PASS rsa_position_keyed_byte_cipher");
    end else begin
      $display("FAIL rsa_position_keyed_byte_cipher");
    end
    $finish;
  end

endmodule
